// File: sv/nru_pkg.sv
`timescale 1ns / 1ps

package nru_pkg;

    localparam int FRAMES    = 16;
    localparam int PAGE_BITS = 16;

    localparam int IDX_W     = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    localparam int CNT_W     = $clog2(FRAMES + 1);
    localparam int CFG_W     = 5;
    localparam int SLOT_W    = 4;
    localparam int EVP_W     = 16;
    localparam int FAULT_W   = 16;

    localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(16);

    typedef struct packed {
        logic [PAGE_BITS-1:0] page;
        logic                 ref_bit;
        logic                 mod_bit;
    } req_t;

    typedef struct packed {
        logic               hit;
        logic [SLOT_W-1:0]  slot;
        logic               evicted;
        logic [EVP_W-1:0]   evicted_page;
        logic [FAULT_W-1:0] fault_total;
    } rsp_t;

    // 0 behaves as 1, anything above the frame count as the frame count
    function automatic logic [CNT_W-1:0] eff_limit(input logic [CFG_W-1:0] v);
        logic [CNT_W-1:0] lim;
        if (v == '0)
            lim = CNT_W'(1);
        else if (32'(v) > FRAMES)
            lim = CNT_W'(FRAMES);
        else
            lim = CNT_W'(v);
        return lim;
    endfunction

endpackage

// File: sv/nru_page_replacement_top.sv
`timescale 1ns / 1ps

// not-recently-used page replacement unit
// input: a reference (page, ref_bit, mod_bit) is taken on a clock edge where
//   start is high and busy is low; busy then stays high until the result
// output: one result per reference, on rsp for exactly one cycle with done
//   high; the receiver cannot hold it off, so the result is simply lost if
//   nobody samples it
// config: cfg_we with cfg_wdata writes frames_in_use (0 acts as 1, values
//   above the frame count act as the frame count); write only while idle
// operation: a hit is found by a scan through the page store, one slot a cycle
//   checked on a registered read; a miss scans all occupied slots, and a
//   replacement then passes through a victim read state and a write state to
//   read out the victim page and write the new one; the victim class search
//   runs alongside the hit scan
// throughput: one reference at a time, held off by busy until its result
// reset: all frames empty, referenced and modified bits clear, fault count
//   zero, frames_in_use back to 16; no clearing pass is needed
module nru_page_replacement_top
    import nru_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  req_t             req,
    output logic             done,
    output rsp_t             rsp,
    input  logic             cfg_we,
    input  logic [CFG_W-1:0] cfg_wdata
);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_SCAN   = 4'b0010,
        S_VREAD  = 4'b0100,
        S_VWRITE = 4'b1000
    } state_t;

    state_t               state_reg, state_next;
    logic [CFG_W-1:0]     cfg_reg;
    logic [CNT_W-1:0]     occ_reg, occ_next;
    logic [FAULT_W-1:0]   fault_reg, fault_next;
    logic [FRAMES-1:0]    ref_reg, ref_next;
    logic [FRAMES-1:0]    mod_reg, mod_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic                 cmp_vld_reg, cmp_vld_next;
    logic [IDX_W-1:0]     cmp_idx_reg, cmp_idx_next;
    logic [2:0]           best_cls_reg, best_cls_next;
    logic [IDX_W-1:0]     best_idx_reg, best_idx_next;
    req_t                 req_reg, req_next;
    logic                 done_reg, done_next;
    rsp_t                 rsp_reg, rsp_next;

    logic [PAGE_BITS-1:0] page_mem [FRAMES];
    logic [PAGE_BITS-1:0] rd_data_reg;
    logic [IDX_W-1:0]     rd_addr;
    logic                 wr_en;
    logic [IDX_W-1:0]     wr_addr;

    logic                 issuing;
    logic [IDX_W-1:0]     scan_idx;
    logic [1:0]           scan_cls;
    logic                 match;
    logic [CNT_W-1:0]     limit;

    assign limit    = eff_limit(cfg_reg);
    assign scan_idx = cnt_reg[IDX_W-1:0];
    assign issuing  = (cnt_reg < occ_reg);
    assign scan_cls = {ref_reg[scan_idx], mod_reg[scan_idx]};
    assign match    = cmp_vld_reg && (rd_data_reg == req_reg.page);
    assign rd_addr  = (state_reg == S_VREAD) ? best_idx_reg : scan_idx;

    always_comb
    begin
        state_next    = state_reg;
        occ_next      = occ_reg;
        fault_next    = fault_reg;
        ref_next      = ref_reg;
        mod_next      = mod_reg;
        cnt_next      = cnt_reg;
        cmp_vld_next  = 1'b0;
        cmp_idx_next  = cmp_idx_reg;
        best_cls_next = best_cls_reg;
        best_idx_next = best_idx_reg;
        req_next      = req_reg;
        done_next     = 1'b0;
        rsp_next      = rsp_reg;
        wr_en         = 1'b0;
        wr_addr       = best_idx_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    req_next      = req;
                    cnt_next      = '0;
                    best_cls_next = 3'd4;
                    best_idx_next = '0;
                    state_next    = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (issuing)
                begin
                    cnt_next     = cnt_reg + CNT_W'(1);
                    cmp_vld_next = 1'b1;
                    cmp_idx_next = scan_idx;
                    if ({1'b0, scan_cls} < best_cls_reg)
                    begin
                        best_cls_next = {1'b0, scan_cls};
                        best_idx_next = scan_idx;
                    end
                end
                if (match)
                begin
                    ref_next[cmp_idx_reg] = 1'b1;
                    rsp_next.hit          = 1'b1;
                    rsp_next.slot         = SLOT_W'(cmp_idx_reg);
                    rsp_next.evicted      = 1'b0;
                    rsp_next.evicted_page = '0;
                    rsp_next.fault_total  = fault_reg;
                    done_next             = 1'b1;
                    cmp_vld_next          = 1'b0;
                    state_next            = S_IDLE;
                end
                else if (!issuing)
                begin
                    // miss
                    fault_next = fault_reg + FAULT_W'(1);
                    if (occ_reg < limit)
                    begin
                        wr_en                 = 1'b1;
                        wr_addr               = occ_reg[IDX_W-1:0];
                        ref_next[wr_addr]     = 1'b0;
                        mod_next[wr_addr]     = 1'b0;
                        occ_next              = occ_reg + CNT_W'(1);
                        rsp_next.hit          = 1'b0;
                        rsp_next.slot         = SLOT_W'(occ_reg[IDX_W-1:0]);
                        rsp_next.evicted      = 1'b0;
                        rsp_next.evicted_page = '0;
                        rsp_next.fault_total  = fault_next;
                        done_next             = 1'b1;
                        state_next            = S_IDLE;
                    end
                    else
                    begin
                        state_next = S_VREAD;
                    end
                end
            end
            S_VREAD:
            begin
                state_next = S_VWRITE;
            end
            S_VWRITE:
            begin
                wr_en                   = 1'b1;
                wr_addr                 = best_idx_reg;
                ref_next[best_idx_reg]  = req_reg.ref_bit;
                mod_next[best_idx_reg]  = req_reg.mod_bit;
                rsp_next.hit            = 1'b0;
                rsp_next.slot           = SLOT_W'(best_idx_reg);
                rsp_next.evicted        = 1'b1;
                rsp_next.evicted_page   = EVP_W'(rd_data_reg);
                rsp_next.fault_total    = fault_reg;
                done_next               = 1'b1;
                state_next              = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            cfg_reg     <= CFG_RESET;
            occ_reg     <= '0;
            fault_reg   <= '0;
            ref_reg     <= '0;
            mod_reg     <= '0;
            cnt_reg     <= '0;
            cmp_vld_reg <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            occ_reg     <= occ_next;
            fault_reg   <= fault_next;
            ref_reg     <= ref_next;
            mod_reg     <= mod_next;
            cnt_reg     <= cnt_next;
            cmp_vld_reg <= cmp_vld_next;
            done_reg    <= done_next;
            if (cfg_we)
            begin
                cfg_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cmp_idx_reg  <= cmp_idx_next;
        best_cls_reg <= best_cls_next;
        best_idx_reg <= best_idx_next;
        req_reg      <= req_next;
        rsp_reg      <= rsp_next;
    end

    // page store, one write and one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            page_mem[wr_addr] <= req_reg.page;
        end
        rd_data_reg <= page_mem[rd_addr];
    end

    assign busy = (state_reg != S_IDLE);
    assign done = done_reg;
    assign rsp  = rsp_reg;

    a_done_after_work: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(state_reg != S_IDLE))
        else $error("result without a transfer in progress");

    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= CNT_W'(FRAMES))
        else $error("occupancy beyond frame count");

    a_evict_not_hit: assert property (@(posedge clk) disable iff (!rst_n)
        done && rsp.evicted |-> !rsp.hit)
        else $error("eviction reported on a hit");

    a_vwrite_follows_vread: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_VREAD |=> state_reg == S_VWRITE)
        else $error("victim read not followed by write");

endmodule

// File: bench/nru_page_replacement_top_tb.sv
`timescale 1ns / 1ps

module nru_page_replacement_top_tb;

    import nru_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int MAX_GAP     = 17;
    localparam int TAIL_CYCLES = 24;
    localparam int POOL_SIZE   = 20;
    localparam int PHASES      = 9;
    localparam int PHASE_REFS  = 50;

    typedef enum logic [1:0] {JOB_REF, JOB_CFG, JOB_DRAIN} job_kind_e;

    typedef struct {
        job_kind_e        kind;
        req_t             item;
        logic [CFG_W-1:0] limit;
        int               gap;
    } job_t;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             start = 1'b0;
    logic             busy;
    req_t             req = '0;
    logic             done;
    rsp_t             rsp;
    logic             cfg_we = 1'b0;
    logic [CFG_W-1:0] cfg_wdata = '0;

    job_t job_q[$];
    rsp_t slot_report_q[$];
    job_t cur_job;
    logic loaded;
    logic we_next;
    rsp_t want_rsp;

    // shadow of the frame table
    logic [PAGE_BITS-1:0] frame_pages [FRAMES];
    logic                 frame_r [FRAMES];
    logic                 frame_m [FRAMES];
    int                   resident;
    logic [15:0]          faults_seen;
    logic [CFG_W-1:0]     frame_limit;

    int          mismatches;
    int          result_no;
    int          hits;
    int          evictions;
    int          refs_sent;
    int          cfg_writes;
    int unsigned cycles;
    logic        quiet_run;

    logic [PAGE_BITS-1:0] pool [POOL_SIZE];
    logic [CFG_W-1:0]     limit_plan [PHASES];

    nru_page_replacement_top i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .req       (req),
        .done      (done),
        .rsp       (rsp),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic rsp_t resolve_reference(input req_t r);
        rsp_t res;
        int   lim;
        int   idx;
        int   best;
        int   cls;
        int   pick;
        bit   found;
        res   = '0;
        found = 1'b0;
        pick  = 0;
        for (idx = 0; idx < resident; idx++)
        begin
            if (!found && frame_pages[idx] == r.page)
            begin
                found = 1'b1;
                pick  = idx;
            end
        end
        if (found)
        begin
            frame_r[pick] = 1'b1;
            res.hit = 1'b1;
        end
        else
        begin
            faults_seen = faults_seen + 16'd1;
            lim = int'(frame_limit);
            if (lim < 1)
                lim = 1;
            if (lim > FRAMES)
                lim = FRAMES;
            if (resident < lim)
            begin
                pick = resident;
                frame_pages[pick] = r.page;
                frame_r[pick] = 1'b0;
                frame_m[pick] = 1'b0;
                resident++;
            end
            else
            begin
                best = 4;
                for (idx = 0; idx < resident; idx++)
                begin
                    cls = 2 * int'(frame_r[idx]) + int'(frame_m[idx]);
                    if (cls < best)
                    begin
                        best = cls;
                        pick = idx;
                    end
                end
                res.evicted      = 1'b1;
                res.evicted_page = 16'(frame_pages[pick]);
                frame_pages[pick] = r.page;
                frame_r[pick] = r.ref_bit;
                frame_m[pick] = r.mod_bit;
            end
        end
        res.slot        = SLOT_W'(pick);
        res.fault_total = faults_seen;
        return res;
    endfunction

    // driver: one transfer at a time, with drains and register writes between them
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start       <= 1'b0;
            cfg_we      <= 1'b0;
            loaded       = 1'b0;
            resident     = 0;
            faults_seen  = '0;
            frame_limit  = CFG_RESET;
            for (int i = 0; i < FRAMES; i++)
            begin
                frame_r[i] = 1'b0;
                frame_m[i] = 1'b0;
            end
        end
        else
        begin
            we_next = 1'b0;
            if (cfg_we)
                frame_limit = cfg_wdata;
            if (start && !busy)
            begin
                slot_report_q.push_back(resolve_reference(req));
                refs_sent++;
                loaded = 1'b0;
            end
            if (!loaded && job_q.size() > 0)
            begin
                if (job_q[0].kind == JOB_REF)
                begin
                    cur_job = job_q.pop_front();
                    loaded  = 1'b1;
                end
                else if (slot_report_q.size() == 0 && !busy)
                begin
                    if (job_q[0].kind == JOB_CFG)
                    begin
                        we_next = 1'b1;
                        cfg_wdata <= job_q[0].limit;
                        cfg_writes++;
                    end
                    void'(job_q.pop_front());
                end
            end
            if (loaded && cur_job.gap == 0)
            begin
                start <= 1'b1;
                req   <= cur_job.item;
            end
            else
            begin
                start <= 1'b0;
                if (loaded)
                    cur_job.gap--;
            end
            cfg_we <= we_next;
        end
    end

    task automatic check_field(input string name, input int n, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
        if (act_v !== exp_v)
        begin
            if (mismatches < 10)
                $display("result %0d: %s expected %0h, got %0h", n, name, exp_v, act_v);
            mismatches++;
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            result_no++;
            if (slot_report_q.size() == 0)
            begin
                if (mismatches < 10)
                    $display("result %0d arrived with nothing outstanding: %p", result_no, rsp);
                mismatches++;
            end
            else
            begin
                want_rsp = slot_report_q.pop_front();
                check_field("hit", result_no, 32'(want_rsp.hit), 32'(rsp.hit));
                check_field("slot", result_no, 32'(want_rsp.slot), 32'(rsp.slot));
                check_field("evicted", result_no, 32'(want_rsp.evicted), 32'(rsp.evicted));
                check_field("evicted_page", result_no, 32'(want_rsp.evicted_page),
                            32'(rsp.evicted_page));
                check_field("fault_total", result_no, 32'(want_rsp.fault_total),
                            32'(rsp.fault_total));
                if (want_rsp.hit)
                    hits++;
                if (want_rsp.evicted)
                    evictions++;
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("timed out with %0d references still queued", job_q.size());
            $display("TEST FAILED");
            $finish;
        end
    end

    function automatic int draw_gap();
        if (quiet_run)
            return 0;
        return $urandom_range(0, MAX_GAP);
    endfunction

    task automatic add_ref(input logic [PAGE_BITS-1:0] pg, input logic r, input logic m);
        job_t j;
        j.kind         = JOB_REF;
        j.item.page    = pg;
        j.item.ref_bit = r;
        j.item.mod_bit = m;
        j.limit        = '0;
        j.gap          = draw_gap();
        job_q.push_back(j);
    endtask

    task automatic add_ctrl(input job_kind_e kind, input logic [CFG_W-1:0] v);
        job_t j;
        j.kind  = kind;
        j.item  = '0;
        j.limit = v;
        j.gap   = 0;
        job_q.push_back(j);
    endtask

    initial
    begin
        int sel;
        quiet_run = 1'b0;

        // ties, class ordering and a lowered limit on a small table
        add_ctrl(JOB_CFG, 5'd3);
        add_ref(16'h0000, 1'b0, 1'b0);
        add_ref(16'hFFFF, 1'b0, 1'b0);
        add_ref(16'h0000, 1'b1, 1'b1);
        add_ref(16'h1234, 1'b0, 1'b0);
        add_ref(16'hFFFF, 1'b0, 1'b0);
        add_ref(16'h0005, 1'b1, 1'b1);
        add_ref(16'h0006, 1'b0, 1'b1);
        add_ref(16'h0007, 1'b1, 1'b0);
        add_ctrl(JOB_DRAIN, '0);
        add_ctrl(JOB_CFG, 5'd1);
        add_ref(16'hFFFF, 1'b0, 1'b0);
        add_ref(16'h8000, 1'b0, 1'b0);
        quiet_run = 1'b1;
        add_ctrl(JOB_CFG, 5'd0);
        add_ref(16'h8000, 1'b1, 1'b1);
        add_ref(16'hAAAA, 1'b0, 1'b0);
        add_ref(16'h5555, 1'b1, 1'b1);
        add_ctrl(JOB_CFG, 5'd31);
        add_ref(16'h0100, 1'b1, 1'b1);
        add_ref(16'h0101, 1'b0, 1'b1);
        add_ref(16'h0102, 1'b1, 1'b0);
        add_ref(16'h0103, 1'b0, 1'b0);
        add_ref(16'h5555, 1'b0, 1'b0);
        add_ref(16'h0100, 1'b1, 1'b1);

        limit_plan = '{5'd16, 5'd1, 5'd31, 5'd0, 5'd17, 5'd4, 5'd16, 5'd9, 5'd2};
        limit_plan[7] = CFG_W'($urandom_range(1, FRAMES));
        for (int i = 0; i < POOL_SIZE; i++)
            pool[i] = PAGE_BITS'($urandom);

        for (int ph = 0; ph < PHASES; ph++)
        begin
            add_ctrl(JOB_CFG, limit_plan[ph]);
            for (int i = 0; i < POOL_SIZE; i++)
                if ($urandom_range(0, 1) == 0)
                    pool[i] = PAGE_BITS'($urandom);
            for (int n = 0; n < PHASE_REFS; n++)
            begin
                if (n % 16 == 0)
                    quiet_run = ($urandom_range(0, 3) == 0);
                if (n == PHASE_REFS / 2 && ph % 3 == 2)
                    add_ctrl(JOB_DRAIN, '0);
                sel = $urandom_range(0, 99);
                if (sel < 70)
                    add_ref(pool[$urandom_range(0, POOL_SIZE - 1)], 1'($urandom), 1'($urandom));
                else if (sel < 90)
                    add_ref(PAGE_BITS'($urandom), 1'($urandom), 1'($urandom));
                else if (sel < 95)
                    add_ref('0, 1'($urandom), 1'($urandom));
                else
                    add_ref('1, 1'($urandom), 1'($urandom));
            end
        end

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        while (job_q.size() != 0 || loaded || slot_report_q.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("%0d references checked: %0d hits, %0d evictions, %0d faults",
                 result_no, hits, evictions, faults_seen);
        $display("%0d limit writes, %0d mismatches, %0d cycles", cfg_writes, mismatches, cycles);
        if (mismatches == 0 && slot_report_q.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// File: nru_page_replacement_top.f
sv/nru_pkg.sv
sv/nru_page_replacement_top.sv
bench/nru_page_replacement_top_tb.sv
